// ----- hdl/mke_pkg.sv -----
// Shared types, constants and the character-to-pattern table for the Morse
// keying encoder. No dependencies; imported by every other module of the block.
package mke_pkg;

  localparam int unsigned DUR_W    = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned EV_CAP   = 64;
  localparam int unsigned EV_CNT_W = 7;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DOT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EGAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LGAP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WGAP = 3'd4;

  // event kinds
  localparam logic [1:0] EV_DOWN  = 2'd0;
  localparam logic [1:0] EV_UP    = 2'd1;
  localparam logic [1:0] EV_PAUSE = 2'd2;

  // duration selects for the duration unit
  localparam logic [2:0] DSEL_DOT   = 3'd0;
  localparam logic [2:0] DSEL_DASH  = 3'd1;
  localparam logic [2:0] DSEL_EGAP  = 3'd2;
  localparam logic [2:0] DSEL_LGAP  = 3'd3;
  localparam logic [2:0] DSEL_PAUSE = 3'd4;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // pattern: len elements, left-aligned in bits (bit 7 first), 1 = dash
  typedef struct packed {
    logic [3:0] len;
    logic [7:0] bits;
  } pat_t;

  typedef struct packed {
    logic [DUR_W-1:0] dot;
    logic [DUR_W-1:0] dash;
    logic [DUR_W-1:0] egap;
    logic [DUR_W-1:0] lgap;
    logic [DUR_W-1:0] wgap;
  } cfg_t;

  typedef struct packed {
    logic       push;
    logic       flush;
    logic [1:0] kind;
    logic [2:0] dsel;
  } emit_t;

  function automatic pat_t letter_pat(logic [4:0] l);
    pat_t p;
    case (l)
      5'd1:    p = '{4'd2, 8'b0100_0000}; // A .-
      5'd2:    p = '{4'd4, 8'b1000_0000}; // B -...
      5'd3:    p = '{4'd4, 8'b1010_0000}; // C -.-.
      5'd4:    p = '{4'd3, 8'b1000_0000}; // D -..
      5'd5:    p = '{4'd1, 8'b0000_0000}; // E .
      5'd6:    p = '{4'd4, 8'b0010_0000}; // F ..-.
      5'd7:    p = '{4'd3, 8'b1100_0000}; // G --.
      5'd8:    p = '{4'd4, 8'b0000_0000}; // H ....
      5'd9:    p = '{4'd2, 8'b0000_0000}; // I ..
      5'd10:   p = '{4'd4, 8'b0111_0000}; // J .---
      5'd11:   p = '{4'd3, 8'b1010_0000}; // K -.-
      5'd12:   p = '{4'd4, 8'b0100_0000}; // L .-..
      5'd13:   p = '{4'd2, 8'b1100_0000}; // M --
      5'd14:   p = '{4'd2, 8'b1000_0000}; // N -.
      5'd15:   p = '{4'd3, 8'b1110_0000}; // O ---
      5'd16:   p = '{4'd4, 8'b0110_0000}; // P .--.
      5'd17:   p = '{4'd4, 8'b1101_0000}; // Q --.-
      5'd18:   p = '{4'd3, 8'b0100_0000}; // R .-.
      5'd19:   p = '{4'd3, 8'b0000_0000}; // S ...
      5'd20:   p = '{4'd1, 8'b1000_0000}; // T -
      5'd21:   p = '{4'd3, 8'b0010_0000}; // U ..-
      5'd22:   p = '{4'd4, 8'b0001_0000}; // V ...-
      5'd23:   p = '{4'd3, 8'b0110_0000}; // W .--
      5'd24:   p = '{4'd4, 8'b1001_0000}; // X -..-
      5'd25:   p = '{4'd4, 8'b1011_0000}; // Y -.--
      5'd26:   p = '{4'd4, 8'b1100_0000}; // Z --..
      default: p = '{4'd0, 8'b0000_0000};
    endcase
    return p;
  endfunction

  function automatic pat_t morse_lookup(logic [6:0] a);
    pat_t p;
    case (a) inside
      7'h21:   p = '{4'd5, 8'b0001_0000};
      7'h22:   p = '{4'd6, 8'b0100_1000};
      7'h24:   p = '{4'd7, 8'b0001_0010};
      7'h25:   p = '{4'd5, 8'b0100_0000};
      7'h27:   p = '{4'd6, 8'b0111_1000};
      7'h28:   p = '{4'd5, 8'b1011_0000};
      7'h29:   p = '{4'd6, 8'b1011_0100};
      7'h2A:   p = '{4'd6, 8'b0001_0100};
      7'h2B:   p = '{4'd5, 8'b0101_0000};
      7'h2C:   p = '{4'd6, 8'b1100_1100};
      7'h2D:   p = '{4'd6, 8'b1000_0100};
      7'h2E:   p = '{4'd6, 8'b0101_0100};
      7'h2F:   p = '{4'd5, 8'b1001_0000};
      7'h30:   p = '{4'd5, 8'b1111_1000};
      7'h31:   p = '{4'd5, 8'b0111_1000};
      7'h32:   p = '{4'd5, 8'b0011_1000};
      7'h33:   p = '{4'd5, 8'b0001_1000};
      7'h34:   p = '{4'd5, 8'b0000_1000};
      7'h35:   p = '{4'd5, 8'b0000_0000};
      7'h36:   p = '{4'd5, 8'b1000_0000};
      7'h37:   p = '{4'd5, 8'b1100_0000};
      7'h38:   p = '{4'd5, 8'b1110_0000};
      7'h39:   p = '{4'd5, 8'b1111_0000};
      7'h3A:   p = '{4'd6, 8'b1110_0000};
      7'h3B:   p = '{4'd6, 8'b1010_1000};
      7'h3D:   p = '{4'd5, 8'b1000_1000};
      7'h3F:   p = '{4'd6, 8'b0011_0000};
      7'h40:   p = '{4'd6, 8'b0110_1000};
      7'h5F:   p = '{4'd6, 8'b0011_0100};
      7'h7F:   p = '{4'd8, 8'b0000_0000};
      [7'h41:7'h5A], [7'h61:7'h7A]: p = letter_pat(a[4:0]);
      default: p = '{4'd0, 8'b0000_0000};
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/mke_dur.sv -----
// Duration unit: picks the event length from the timing registers and forms
// the word pause with one saturating subtractor. Depends on mke_pkg.
module mke_dur (
  input  logic [2:0]                 dsel_i,
  input  mke_pkg::cfg_t              cfg_i,
  output logic [mke_pkg::DUR_W-1:0]  dur_o
);
  import mke_pkg::*;

  logic [DUR_W:0] diff;

  assign diff = {1'b0, cfg_i.wgap} - {1'b0, cfg_i.lgap};

  always_comb begin
    case (dsel_i)
      DSEL_DOT:   dur_o = cfg_i.dot;
      DSEL_DASH:  dur_o = cfg_i.dash;
      DSEL_EGAP:  dur_o = cfg_i.egap;
      DSEL_LGAP:  dur_o = cfg_i.lgap;
      DSEL_PAUSE: dur_o = diff[DUR_W] ? '0 : diff[DUR_W-1:0]; // clamp at zero
      default:    dur_o = '0;
    endcase
  end

endmodule

// ----- hdl/mke_evbuf.sv -----
// Event buffer: one pending event plus the output register. The pending slot
// lets the final event of a transaction be tagged last. Depends on mke_pkg.
module mke_evbuf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mke_pkg::emit_t             emit_i,
  input  logic [mke_pkg::DUR_W-1:0]  dur_i,
  output logic                       rdy_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 out_kind_o,
  output logic [mke_pkg::DUR_W-1:0]  out_dur_o,
  output logic                       out_last_o
);
  import mke_pkg::*;

  logic             pend_v_q, pend_v_d;
  logic [1:0]       pend_kind_q;
  logic [DUR_W-1:0] pend_dur_q;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_kind_q;
  logic [DUR_W-1:0] out_dur_q;
  logic             out_last_q;
  logic             out_free, move_out, load_pend;

  assign out_free  = !out_valid_q || out_ready_i;
  assign rdy_o     = !pend_v_q || out_free;
  assign move_out  = pend_v_q && out_free && (emit_i.push || emit_i.flush);
  assign load_pend = emit_i.push && rdy_o;

  always_comb begin
    pend_v_d = pend_v_q;
    if (load_pend) begin
      pend_v_d = 1'b1;
    end else if (emit_i.flush && rdy_o) begin
      pend_v_d = 1'b0;
    end
    out_valid_d = move_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_pend) begin
      pend_kind_q <= emit_i.kind;
      pend_dur_q  <= dur_i;
    end
    if (move_out) begin
      out_kind_q <= pend_kind_q;
      out_dur_q  <= pend_dur_q;
      out_last_q <= emit_i.flush;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_dur_o   = out_dur_q;
  assign out_last_o  = out_last_q;

  a_flush_tags_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_i.flush && rdy_o && pend_v_q |=> out_valid_o && out_last_o)
    else $error("flushed event not presented as last");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_i.flush && rdy_o |=> !pend_v_q)
    else $error("pending slot not emptied by flush");

endmodule

// ----- hdl/mke_seq.sv -----
// Sequencer: prosign hold buffer and counters, pattern lookup, and the
// element walk that issues one keying event per step. Depends on mke_pkg.
module mke_seq #(
  parameter int unsigned MAX_PROSIGN = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     char_code_i,
  input  logic           buf_rdy_i,
  output mke_pkg::emit_t emit_o
);
  import mke_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PROSIGN + 1);
  localparam int unsigned IdxW = $clog2(MAX_PROSIGN);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_DOWN  = 3'd2;
  localparam logic [2:0] ST_UP    = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CntW-1:0]     slash_q, slash_d, held_cnt_q, held_cnt_d;
  logic [7:0]          held_q [MAX_PROSIGN];
  logic [IdxW-1:0]     ci_q, ci_d, last_ci_q, last_ci_d;
  logic [7:0]          bits_q, bits_d;
  logic [3:0]          len_q, len_d, k_q, k_d;
  logic [EV_CNT_W-1:0] ev_cnt_q, ev_cnt_d;

  logic       accept, hold_we, want, req, step, last_el, last_ch;
  logic [7:0] cur_char;
  pat_t       pat;

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign cur_char = held_q[ci_q];
  assign pat      = morse_lookup(cur_char[6:0]);
  assign last_el  = (k_q == len_q - 4'd1);
  assign last_ch  = (ci_q == last_ci_q);
  // every non-backslash is written to the hold buffer; a plain character
  // lands in entry zero and is released at once
  assign hold_we  = accept && (char_code_i != CH_BACKSLASH);

  always_comb begin
    want       = 1'b0;
    emit_o     = '0;
    case (state_q)
      ST_LOAD: begin
        want        = (pat.len == 4'd0) && (cur_char == CH_SPACE);
        emit_o.kind = EV_PAUSE;
        emit_o.dsel = DSEL_PAUSE;
      end
      ST_DOWN: begin
        want        = 1'b1;
        emit_o.kind = EV_DOWN;
        emit_o.dsel = bits_q[7] ? DSEL_DASH : DSEL_DOT;
      end
      ST_UP: begin
        want        = 1'b1;
        emit_o.kind = EV_UP;
        emit_o.dsel = (last_el && last_ch) ? DSEL_LGAP : DSEL_EGAP;
      end
      ST_FLUSH: emit_o.flush = 1'b1;
      default: ;
    endcase
    // events past the cap are dropped
    req         = want && (ev_cnt_q != EV_CNT_W'(EV_CAP));
    emit_o.push = req;
    step        = !req || buf_rdy_i;
  end

  always_comb begin
    state_d    = state_q;
    slash_d    = slash_q;
    held_cnt_d = held_cnt_q;
    ci_d       = ci_q;
    last_ci_d  = last_ci_q;
    bits_d     = bits_q;
    len_d      = len_q;
    k_d        = k_q;
    ev_cnt_d   = (req && buf_rdy_i) ? ev_cnt_q + EV_CNT_W'(1) : ev_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (char_code_i == CH_BACKSLASH) begin
            if (slash_q < CntW'(MAX_PROSIGN - 1)) slash_d = slash_q + CntW'(1);
          end else if (held_cnt_q >= slash_q) begin
            ci_d       = '0;
            last_ci_d  = held_cnt_q[IdxW-1:0];
            held_cnt_d = '0;
            slash_d    = '0;
            ev_cnt_d   = '0;
            state_d    = ST_LOAD;
          end else begin
            held_cnt_d = held_cnt_q + CntW'(1);
          end
        end
      end
      ST_LOAD: begin
        if (pat.len != 4'd0) begin
          bits_d  = pat.bits;
          len_d   = pat.len;
          k_d     = 4'd0;
          state_d = ST_DOWN;
        end else if (step) begin
          if (last_ch) state_d = ST_FLUSH;
          else ci_d = ci_q + IdxW'(1);
        end
      end
      ST_DOWN: begin
        if (step) state_d = ST_UP;
      end
      ST_UP: begin
        if (step) begin
          bits_d = {bits_q[6:0], 1'b0};
          k_d    = k_q + 4'd1;
          if (!last_el) begin
            state_d = ST_DOWN;
          end else if (last_ch) begin
            state_d = ST_FLUSH;
          end else begin
            ci_d    = ci_q + IdxW'(1);
            state_d = ST_LOAD;
          end
        end
      end
      ST_FLUSH: begin
        if (buf_rdy_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slash_q    <= '0;
      held_cnt_q <= '0;
      ev_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      slash_q    <= slash_d;
      held_cnt_q <= held_cnt_d;
      ev_cnt_q   <= ev_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ci_q      <= ci_d;
    last_ci_q <= last_ci_d;
    bits_q    <= bits_d;
    len_q     <= len_d;
    k_q       <= k_d;
    if (hold_we) held_q[held_cnt_q[IdxW-1:0]] <= char_code_i;
  end

  a_slash_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slash_q <= CntW'(MAX_PROSIGN - 1))
    else $error("slash count above saturation");

  a_held_below_slash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q <= slash_q)
    else $error("held count passed slash count");

  a_ev_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_cnt_q <= EV_CNT_W'(EV_CAP))
    else $error("event count above cap");

  a_push_not_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit_o.push && emit_o.flush))
    else $error("push and flush together");

endmodule

// ----- hdl/ascii_to_morse_keying_unit.sv -----
// Top level of the ASCII to Morse keying encoder: timing registers, the
// sequencer, the duration unit and the event buffer. Depends on mke_pkg.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   char_code_i[7:0]
//   out      out  out_valid_o / out_ready_i event_kind_o[1:0], duration_o[19:0], last_o
//   cfg      in   cfg_we_i (no wait)        cfg_idx_i[2:0], cfg_wdata_i[19:0]
//
// Each character is taken in the idle state; each released character then
// passes a lookup state and a down and an up state per dot/dash (a space
// pause goes out in its lookup state), and a flush state ends the transaction.
// The sequencer walks one event per cycle through the shared duration unit; a
// full pending slot and output register stall the walk until out_ready_i.
// Backslashes and held prosign characters emit nothing. in_ready_o is high
// only while the sequencer is idle. Reset clears control state and loads the
// default timings; held characters are not cleared.
module ascii_to_morse_keying_unit #(
  parameter int unsigned MAX_PROSIGN = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        char_code_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        event_kind_o,
  output logic [mke_pkg::DUR_W-1:0]         duration_o,
  output logic                              last_o,
  input  logic                              cfg_we_i,
  input  logic [mke_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mke_pkg::DUR_W-1:0]         cfg_wdata_i
);
  import mke_pkg::*;

  cfg_t             cfg_q;
  emit_t            emit;
  logic             buf_rdy;
  logic [DUR_W-1:0] dur;

  // timing registers; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot  <= DUR_W'(2880);
      cfg_q.dash <= DUR_W'(8640);
      cfg_q.egap <= DUR_W'(2880);
      cfg_q.lgap <= DUR_W'(8640);
      cfg_q.wgap <= DUR_W'(20160);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DOT:  cfg_q.dot  <= cfg_wdata_i;
        CFG_DASH: cfg_q.dash <= cfg_wdata_i;
        CFG_EGAP: cfg_q.egap <= cfg_wdata_i;
        CFG_LGAP: cfg_q.lgap <= cfg_wdata_i;
        CFG_WGAP: cfg_q.wgap <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer: decides which event comes next and when a transaction is done
  mke_seq #(
    .MAX_PROSIGN(MAX_PROSIGN)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .buf_rdy_i   (buf_rdy),
    .emit_o      (emit)
  );

  // shared duration unit
  mke_dur u_dur (
    .dsel_i (emit.dsel),
    .cfg_i  (cfg_q),
    .dur_o  (dur)
  );

  // one event held back so the final one can carry last
  mke_evbuf u_evbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .dur_i       (dur),
    .rdy_o       (buf_rdy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (event_kind_o),
    .out_dur_o   (duration_o),
    .out_last_o  (last_o)
  );

  a_idle_no_output_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.flush && buf_rdy |=> in_ready_o)
    else $error("sequencer not idle after flush");

endmodule
